### rtl/fvr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the framed value receiver.
// No dependencies; imported by fvr_ring and framed_value_receiver.
package fvr_pkg;

	// Command codes on the input beat
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	// Frame bytes
	localparam logic [7:0] LABEL_BONUS = 8'd85;
	localparam logic [7:0] LABEL_B     = 8'd86;
	localparam logic [7:0] LABEL_C     = 8'd89;
	localparam logic [7:0] LABEL_D     = 8'd82;
	localparam logic [7:0] LABEL_E     = 8'd100;
	localparam logic [7:0] LABEL_F     = 8'd60;
	localparam logic [7:0] END_MARK    = 8'd160;

	// Value handling
	localparam logic [31:0] NO_MSG     = 32'hFFFF_FFFF;
	localparam logic [31:0] NO_MSG_SUB = 32'hFFFF_FFFE;
	localparam logic [31:0] BONUS_ADD  = 32'd130;

	// Minimum free slots to accept an arriving byte
	localparam int unsigned FREE_MIN = 6;

	// Frame phases
	typedef logic [2:0] phase_t;
	localparam phase_t PH_LABEL = 3'd0;
	localparam phase_t PH_VAL0  = 3'd1;
	localparam phase_t PH_VAL3  = 3'd4;
	localparam phase_t PH_END   = 3'd5;

	typedef enum logic {
		ST_IDLE,
		ST_DATA
	} fvr_state_t;

	typedef struct packed {
		logic empty;
		logic room;
	} ring_status_t;

	function automatic logic label_ok(input logic [7:0] b);
		return b inside {LABEL_BONUS, LABEL_B, LABEL_C, LABEL_D, LABEL_E, LABEL_F};
	endfunction

endpackage

### rtl/fvr_ring.sv
`timescale 1ns / 1ps
// Receive ring buffer: byte memory with registered read, plus indices.
// Depends on fvr_pkg.
module fvr_ring
	import fvr_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [7:0]   wr_data,
	input  logic         rd_en,
	output logic [7:0]   rd_data,
	output ring_status_t status
);

	localparam int unsigned IW = $clog2(DEPTH);

	logic [7:0]  mem [DEPTH];
	logic [IW-1:0] rd_idx_q;
	logic [IW-1:0] wr_idx_q;
	logic [7:0]  rd_data_q;
	logic [IW:0] free_slots;

	function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] idx);
		return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	// free = rd - wr, plus DEPTH when that is zero or negative
	always_comb begin
		if (rd_idx_q > wr_idx_q) begin
			free_slots = {1'b0, rd_idx_q} - {1'b0, wr_idx_q};
		end else begin
			free_slots = {1'b0, rd_idx_q} + (IW+1)'(DEPTH) - {1'b0, wr_idx_q};
		end
	end

	assign status.empty = (rd_idx_q == wr_idx_q);
	assign status.room  = (free_slots >= (IW+1)'(FREE_MIN));
	assign rd_data      = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
		end else begin
			if (wr_en) begin
				wr_idx_q <= inc_wrap(wr_idx_q);
			end
			if (rd_en) begin
				rd_idx_q <= inc_wrap(rd_idx_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !status.empty)
		else $error("pop from empty ring");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> status.room)
		else $error("push without room");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> !status.empty)
		else $error("ring empty after push");

endmodule

### rtl/framed_value_receiver.sv
`timescale 1ns / 1ps
// Framed value receiver: beat control, frame parse state machine, result register.
// Depends on fvr_pkg and fvr_ring.

// Input beats carry either a received line byte (cmd 0) or a poll (cmd 1);
// every input beat yields exactly one result beat. A byte beat stores the
// byte in a BUF_DEPTH-entry ring buffer, or drops it (byte_dropped set) when
// fewer than six slots are free. A poll resumes the frame parse where the
// last poll left it: label byte (85, 86, 89, 82, 100 or 60), four value
// bytes least significant first, end byte 160. It pops 0 to 6 bytes, one
// per cycle, through the buffer memory's registered read. The poll stops
// early when the buffer runs dry or a byte is not a valid label; those
// return -1. A bad end byte returns -1 with frame_error. A good frame
// returns the value (plus 130 for label 85, with -1 mapped to -2) and
// value_valid. byte_dropped and last_label show the current drop flag and
// the latest byte examined as a label. The next beat is taken only when no
// poll is in progress and the output register is empty or its result beat
// is accepted in that same cycle.
// Buffer memory needs no clearing; only written entries are ever read.
module framed_value_receiver
	import fvr_pkg::*;
#(
	parameter int unsigned BUF_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [7:0]         rx_byte,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               value_valid,
	output logic               frame_error,
	output logic               byte_dropped,
	output logic [7:0]         last_label
);

	fvr_state_t   state_q, state_d;
	phase_t       phase_q, phase_d;
	logic [7:0]   label_q, label_d;
	logic [31:0]  value_q, value_d;
	logic         drop_q, drop_d;

	logic         in_acc;
	logic         wr_en, rd_en;
	logic [7:0]   rd_data;
	ring_status_t ring_st;

	// result staging
	logic         load;
	logic [31:0]  res_val;
	logic         res_ok, res_err;
	logic         fin;
	logic [1:0]   lane;
	logic [31:0]  sum;

	logic               out_valid_q;
	logic signed [31:0] result_value_q;
	logic               value_valid_q;
	logic               frame_error_q;
	logic               byte_dropped_q;
	logic [7:0]         last_label_q;

	fvr_ring #(
		.DEPTH(BUF_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.status  (ring_st)
	);

	// Take a beat only between polls, and only when the result slot frees up
	assign in_stall = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall));
	assign in_acc   = in_valid && !in_stall;

	// value byte lane for phases 1..4
	assign lane = phase_q[1:0] - 2'd1;

	// completed frame value with label bonus
	assign sum = value_q + ((label_q == LABEL_BONUS) ? BONUS_ADD : 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_LABEL;
			label_q <= '0;
			value_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			label_q <= label_d;
			value_q <= value_d;
			drop_q  <= drop_d;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		label_d = label_q;
		value_d = value_q;
		drop_d  = drop_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		load    = 1'b0;
		fin     = 1'b0;
		res_val = NO_MSG;
		res_ok  = 1'b0;
		res_err = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_BYTE) begin
						load = 1'b1;
						if (ring_st.room) begin
							wr_en  = 1'b1;
							drop_d = 1'b0;
						end else begin
							drop_d = 1'b1;
						end
					end else begin
						// unused phase codes restart the search
						if (phase_q > PH_END) begin
							phase_d = PH_LABEL;
						end
						if (ring_st.empty) begin
							load = 1'b1;
						end else begin
							rd_en   = 1'b1;
							state_d = ST_DATA;
						end
					end
				end
			end
			ST_DATA: begin
				case (phase_q)
					PH_LABEL: begin
						label_d = rd_data;
						if (label_ok(rd_data)) begin
							phase_d = PH_VAL0;
						end else begin
							fin = 1'b1;
						end
					end
					PH_END: begin
						phase_d = PH_LABEL;
						fin     = 1'b1;
						if (rd_data != END_MARK) begin
							res_err = 1'b1;
						end else begin
							res_ok  = 1'b1;
							res_val = (sum == NO_MSG) ? NO_MSG_SUB : sum;
						end
					end
					default: begin
						if (phase_q >= PH_VAL0 && phase_q <= PH_VAL3) begin
							value_d[{lane, 3'b000} +: 8] = rd_data;
							phase_d = phase_q + 3'd1;
						end else begin
							phase_d = PH_LABEL;
							fin     = 1'b1;
						end
					end
				endcase
				if (fin || ring_st.empty) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					rd_en = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_value_q <= signed'(res_val);
			value_valid_q  <= res_ok;
			frame_error_q  <= res_err;
			byte_dropped_q <= drop_d;
			last_label_q   <= label_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign value_valid  = value_valid_q;
	assign frame_error  = frame_error_q;
	assign byte_dropped = byte_dropped_q;
	assign last_label   = last_label_q;

	a_slot_free_in_parse: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> !out_valid_q)
		else $error("result pending during parse");

	a_valid_not_nomsg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && value_valid_q) |-> (result_value_q != signed'(NO_MSG)))
		else $error("completed message reads as no message");

	a_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_error_q) |-> (!value_valid_q
			&& result_value_q == signed'(NO_MSG)))
		else $error("frame error with a message value");

endmodule

### tb/tb_framed_value_receiver.sv
`timescale 1ns / 1ps
// Self-checking testbench for framed_value_receiver: directed frame cases,
// buffer overflow floods and random framed traffic against an in-bench predictor.
// Depends on fvr_pkg and the framed_value_receiver RTL.
module tb_framed_value_receiver;
	import fvr_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int RANDOM_BEATS = 800;

	// receiver back-pressure styles
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_RUNS
	} stall_style_t;

	// one expected result beat
	typedef struct {
		logic [31:0] value;
		logic        msg_ok;
		logic        ferr;
		logic        dropped;
		logic [7:0]  label;
	} beat_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = CMD_BYTE;
	logic [7:0]         rx_byte = 8'd0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] result_value;
	logic               value_valid;
	logic               frame_error;
	logic               byte_dropped;
	logic [7:0]         last_label;

	framed_value_receiver #(
		.BUF_DEPTH(DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_value(result_value),
		.value_valid (value_valid),
		.frame_error (frame_error),
		.byte_dropped(byte_dropped),
		.last_label  (last_label)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: a mirror of the ring buffer and the frame parser
	logic [7:0]       mirror_store [DEPTH];
	logic [IDX_W-1:0] mirror_rd = '0;
	logic [IDX_W-1:0] mirror_wr = '0;
	phase_t           mirror_phase = PH_LABEL;
	logic [7:0]       mirror_label = 8'd0;
	logic [31:0]      mirror_value = 32'd0;
	logic             mirror_drop = 1'b0;

	beat_result_t awaited_results[$];
	int           err_count = 0;
	int           beats_sent = 0;

	// sender idling: gap_max 0 means back-to-back beats
	int           gap_max = 0;
	int           burst_left = 0;
	stall_style_t stall_style = STALL_NONE;
	int           stall_run = 0;

	function automatic logic is_frame_label(input logic [7:0] b);
		case (b)
			LABEL_BONUS, LABEL_B, LABEL_C, LABEL_D, LABEL_E, LABEL_F: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Advances the mirror by one accepted input beat and returns its result.
	function automatic beat_result_t parse_beat(input logic c, input logic [7:0] b);
		beat_result_t r;
		int           free_slots;
		logic         stopped;
		logic [7:0]   pb;
		logic [31:0]  v;
		r.value = NO_MSG;
		r.msg_ok = 1'b0;
		r.ferr = 1'b0;
		if (c == CMD_BYTE) begin
			// free slots: rd - wr, wrapping so an empty ring has DEPTH free
			if (mirror_rd > mirror_wr)
				free_slots = int'(mirror_rd) - int'(mirror_wr);
			else
				free_slots = int'(mirror_rd) + DEPTH - int'(mirror_wr);
			if (free_slots < FREE_MIN) begin
				mirror_drop = 1'b1;
			end else begin
				mirror_drop = 1'b0;
				mirror_store[mirror_wr] = b;
				mirror_wr = mirror_wr + 1'b1;
			end
		end else begin
			stopped = 1'b0;
			if (mirror_phase > PH_END)
				mirror_phase = PH_LABEL;
			if (mirror_phase == PH_LABEL) begin
				if (mirror_rd == mirror_wr) begin
					stopped = 1'b1;
				end else begin
					pb = mirror_store[mirror_rd];
					mirror_rd = mirror_rd + 1'b1;
					mirror_label = pb;
					if (!is_frame_label(pb))
						stopped = 1'b1;
					else
						mirror_phase = PH_VAL0;
				end
			end
			while (!stopped && mirror_phase >= PH_VAL0 && mirror_phase <= PH_VAL3) begin
				if (mirror_rd == mirror_wr) begin
					stopped = 1'b1;
				end else begin
					pb = mirror_store[mirror_rd];
					mirror_rd = mirror_rd + 1'b1;
					mirror_value[8 * (mirror_phase - PH_VAL0) +: 8] = pb;
					mirror_phase = mirror_phase + 3'd1;
				end
			end
			if (!stopped && mirror_rd != mirror_wr) begin
				pb = mirror_store[mirror_rd];
				mirror_rd = mirror_rd + 1'b1;
				mirror_phase = PH_LABEL;
				if (pb != END_MARK) begin
					r.ferr = 1'b1;
				end else begin
					v = mirror_value;
					if (mirror_label == LABEL_BONUS)
						v = v + BONUS_ADD;
					// -1 is reserved for "no message"
					if (v == NO_MSG)
						v = NO_MSG_SUB;
					r.value = v;
					r.msg_ok = 1'b1;
				end
			end
		end
		r.dropped = mirror_drop;
		r.label = mirror_label;
		return r;
	endfunction

	// Sends one input beat; bursts of random length are separated by random gaps.
	// The expectation is queued at the edge where the beat is accepted.
	task automatic send_beat(input logic c, input logic [7:0] b);
		int gap;
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, gap_max);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left--;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		awaited_results.push_back(parse_beat(c, b));
		beats_sent++;
	endtask

	// rx_byte is don't-care on a poll; keep it moving anyway
	task automatic poll_once();
		send_beat(CMD_POLL, 8'($urandom));
	endtask

	task automatic send_frame(input logic [7:0] lbl, input logic [31:0] v,
			input logic [7:0] end_byte);
		send_beat(CMD_BYTE, lbl);
		for (int i = 0; i < 4; i++)
			send_beat(CMD_BYTE, v[8 * i +: 8]);
		send_beat(CMD_BYTE, end_byte);
	endtask

	function automatic logic [7:0] pick_label();
		case ($urandom_range(0, 5))
			0: return LABEL_BONUS;
			1: return LABEL_B;
			2: return LABEL_C;
			3: return LABEL_D;
			4: return LABEL_E;
			default: return LABEL_F;
		endcase
	endfunction

	// biased toward the sign and wrap corners
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return NO_MSG;
			3: return NO_MSG - BONUS_ADD;   // becomes -1 under the label 85 bonus
			4: return 32'd0;
			5: return 32'hFFFF_FFF0;        // bonus wraps past zero
			default: return $urandom;
		endcase
	endfunction

	task automatic set_idling(input int gmax, input stall_style_t style);
		gap_max = gmax;
		burst_left = 0;
		stall_style = style;
	endtask

	// Receiver back-pressure, changed on the falling edge only
	always @(negedge clk) begin
		case (stall_style)
			STALL_NONE: out_stall <= 1'b0;
			STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_run > 0) begin
					stall_run <= stall_run - 1;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 9) == 0)
						stall_run <= $urandom_range(1, 12);
				end
			end
		endcase
	end

	// Result checker: every accepted result beat against the oldest expectation
	always @(posedge clk) begin
		beat_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("%0t: result beat with nothing expected (value %h)",
						$time, result_value);
			end else begin
				e = awaited_results.pop_front();
				if (result_value !== e.value || value_valid !== e.msg_ok ||
						frame_error !== e.ferr || byte_dropped !== e.dropped ||
						last_label !== e.label) begin
					err_count++;
					if (err_count <= 10) begin
						$display("%0t: mismatch exp value %h ok %b ferr %b drop %b label %0d",
							$time, e.value, e.msg_ok, e.ferr, e.dropped, e.label);
						$display("%0t:          got value %h ok %b ferr %b drop %b label %0d",
							$time, result_value, value_valid, frame_error, byte_dropped,
							last_label);
					end
				end
			end
		end
	end

	// --- directed tests ---

	// poll with nothing buffered
	task automatic test_empty_poll();
		poll_once();
	endtask

	// a plain frame carrying -1 must come back as -2
	task automatic test_minus_one_remap();
		send_frame(LABEL_B, NO_MSG, END_MARK);
		poll_once();
	endtask

	// label 85 adds 130; here the sum lands on -1 and is remapped too
	task automatic test_bonus_wrap();
		send_frame(LABEL_BONUS, NO_MSG - BONUS_ADD, END_MARK);
		poll_once();
	endtask

	// poll runs dry mid-frame, resumes later and meets a bad end byte
	task automatic test_split_bad_end();
		send_beat(CMD_BYTE, LABEL_F);
		send_beat(CMD_BYTE, 8'hFF);
		send_beat(CMD_BYTE, 8'h00);
		poll_once();
		send_beat(CMD_BYTE, 8'h80);
		send_beat(CMD_BYTE, 8'h7F);
		send_beat(CMD_BYTE, 8'h00);
		poll_once();
	endtask

	// a non-label byte is consumed and the search goes on
	task automatic test_bad_label();
		send_beat(CMD_BYTE, 8'h00);
		poll_once();
	endtask

	// fill the ring past its threshold so bytes get dropped, then drain it
	task automatic test_overflow();
		for (int round = 0; round < 2; round++) begin
			set_idling(round * 4, round == 0 ? STALL_NONE : STALL_RANDOM);
			for (int k = 0; k < 11; k++)
				send_frame(pick_label(), pick_value(), END_MARK);
			while (mirror_rd != mirror_wr)
				poll_once();
		end
	endtask

	// Mostly well-formed frames with random content; polls land anywhere,
	// plus noise bytes, broken end bytes and stray polls.
	task automatic test_random_frames();
		int          start;
		int          sel;
		logic [7:0]  lbl;
		logic [31:0] v;
		logic [7:0]  end_byte;
		start = beats_sent;
		while (beats_sent - start < RANDOM_BEATS) begin
			// change the idling style every so often, including quiet stretches
			if ($urandom_range(0, 19) == 0)
				set_idling($urandom_range(0, 1) * $urandom_range(1, 8),
					stall_style_t'($urandom_range(0, 2)));
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				lbl = pick_label();
				v = pick_value();
				end_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom) : END_MARK;
				send_beat(CMD_BYTE, lbl);
				for (int i = 0; i < 4; i++) begin
					if ($urandom_range(0, 9) == 0)
						poll_once();
					send_beat(CMD_BYTE, v[8 * i +: 8]);
				end
				send_beat(CMD_BYTE, end_byte);
				if ($urandom_range(0, 9) < 7)
					poll_once();
			end else if (sel < 85) begin
				send_beat(CMD_BYTE, 8'($urandom));
			end else begin
				poll_once();
			end
		end
	endtask

	initial begin
		// reset held low from the start, released on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_idling(0, STALL_NONE);
		test_empty_poll();
		test_minus_one_remap();
		set_idling(3, STALL_RUNS);
		test_bonus_wrap();
		test_split_bad_end();
		test_bad_label();
		test_overflow();
		test_random_frames();

		@(negedge clk);
		in_valid <= 1'b0;
		stall_style = STALL_NONE;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("framed_value_receiver regression: pass");
		else
			$display("framed_value_receiver regression: fail");
		$finish;
	end

	// Watchdog: a correct run needs well under a millisecond
	initial begin
		#5_000_000;
		$display("framed_value_receiver regression: fail");
		$finish;
	end

endmodule

### framed_value_receiver.f
rtl/fvr_pkg.sv
rtl/fvr_ring.sv
rtl/framed_value_receiver.sv
tb/tb_framed_value_receiver.sv
